// ===== rtl/apsq_pkg.sv =====
// Shared types, widths and constants for the box point surface query block.
`timescale 1ns / 1ps

package apsq_pkg;

	localparam int COORD_W = 32;
	localparam int CENTER_W = 31;
	localparam int HALF_W = 30;
	localparam int DIST_W = 31;
	localparam int NORM_W = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 31;
	localparam int NUM_AXES = 3;

	localparam int IN_TDATA_W = 96;
	localparam int OUT_FIELDS_W = 1 + 3 * COORD_W + 3 * NORM_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int QUEUE_DEPTH_DEF = 4;

	// Unit normal magnitudes in Q2.14: one, two or three faces touched.
	localparam logic [NORM_W-1:0] NORM_ONE = 16'd16384;
	localparam logic [NORM_W-1:0] NORM_SQRT2 = 16'd11585;
	localparam logic [NORM_W-1:0] NORM_SQRT3 = 16'd9459;

	localparam logic [HALF_W-1:0] HALF_RESET = 30'd65536;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_HALF_X = 3'd3,
		CFG_HALF_Y = 3'd4,
		CFG_HALF_Z = 3'd5
	} cfg_idx_t;

	// Bounds of the box on one axis, kept ready from the configuration.
	typedef struct packed {
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic flat;
	} axis_bounds_t;

	typedef axis_bounds_t [NUM_AXES-1:0] box_t;

	// Classification of one coordinate against its slab.
	typedef struct packed {
		logic [COORD_W-1:0] p;
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic below;
		logic above;
		logic eq_lo;
		logic eq_hi;
		logic flat;
		logic [DIST_W-1:0] dmin;
		logic [DIST_W-1:0] dmax;
	} axis_info_t;

	typedef struct packed {
		logic is_inside;
		axis_info_t [NUM_AXES-1:0] ax;
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [NORM_W-1:0] norm_scale(input logic [1:0] cnt);
		logic [NORM_W-1:0] s;
		case (cnt)
			2'd1: s = NORM_ONE;
			2'd2: s = NORM_SQRT2;
			2'd3: s = NORM_SQRT3;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/aabb_point_surface_query_core.sv =====
// Top level of the box point surface query block: configuration, front end, queue, back end.
`timescale 1ns / 1ps

// Closest point on an axis-aligned box, with the face normal, for a stream of points.
//
// The slave stream carries one query point per transfer (x, y, z in Q16.16). The
// master stream returns one result per point, in order: the inside flag, the
// closest surface point in Q16.16 and the unit face normal in Q2.14.
// The box is set through the write port: center x/y/z, then half extents x/y/z.
// Box bounds are formed when a register is written, so writes must happen while
// no point is in flight; a point may follow in the cycle after the write.
// Throughput is one point per clock while the receiver holds m_axis_tready high.
// An accepted point is moved from the queue into the per-axis face stage and from
// that stage on into the output register. The output register holds a
// result while tready is low; the front end keeps taking points until the queue
// between the two halves (QUEUE_DEPTH entries) is full, so QUEUE_DEPTH plus two
// results can be held under a stalled receiver before s_axis_tready drops.
// Reset clears the queue and both valid flags and sets the box to center zero
// with half extent 1.0 on each axis.

module aabb_point_surface_query_core
	import apsq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata, // point_x, point_y, point_z
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// inside_res, surf_x, surf_y, surf_z, norm_x, norm_y, norm_z, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [CENTER_W-1:0] center_q [NUM_AXES];
	logic [HALF_W-1:0] half_q [NUM_AXES];
	logic [COORD_W-1:0] lo_q [NUM_AXES];
	logic [COORD_W-1:0] hi_q [NUM_AXES];
	logic [NUM_AXES-1:0] flat_q;

	logic [COORD_W-1:0] lo_c [NUM_AXES];
	logic [COORD_W-1:0] hi_c [NUM_AXES];
	logic [COORD_W-1:0] lo_h [NUM_AXES];
	logic [COORD_W-1:0] hi_h [NUM_AXES];
	logic [COORD_W-1:0] w_center;
	logic [COORD_W-1:0] w_half;

	box_t box;
	q_status_t q_stat;
	logic push;
	cls_t push_data;
	logic pop;
	cls_t pop_data;

	// New bounds for a center write (with the held half extent) and for a half
	// extent write (with the held center). Both always fit in 32 signed bits.
	assign w_center = {cfg_wdata[CENTER_W-1], cfg_wdata};
	assign w_half = {2'b00, cfg_wdata[HALF_W-1:0]};

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			lo_c[a] = w_center - {2'b00, half_q[a]};
			hi_c[a] = w_center + {2'b00, half_q[a]};
			lo_h[a] = {center_q[a][CENTER_W-1], center_q[a]} - w_half;
			hi_h[a] = {center_q[a][CENTER_W-1], center_q[a]} + w_half;
			box[a].lo = lo_q[a];
			box[a].hi = hi_q[a];
			box[a].flat = flat_q[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				center_q[a] <= '0;
				half_q[a] <= HALF_RESET;
				lo_q[a] <= -{2'b00, HALF_RESET};
				hi_q[a] <= {2'b00, HALF_RESET};
			end
			flat_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_CENTER_X: begin
					center_q[0] <= cfg_wdata;
					lo_q[0] <= lo_c[0];
					hi_q[0] <= hi_c[0];
				end
				CFG_CENTER_Y: begin
					center_q[1] <= cfg_wdata;
					lo_q[1] <= lo_c[1];
					hi_q[1] <= hi_c[1];
				end
				CFG_CENTER_Z: begin
					center_q[2] <= cfg_wdata;
					lo_q[2] <= lo_c[2];
					hi_q[2] <= hi_c[2];
				end
				CFG_HALF_X: begin
					half_q[0] <= cfg_wdata[HALF_W-1:0];
					lo_q[0] <= lo_h[0];
					hi_q[0] <= hi_h[0];
					flat_q[0] <= cfg_wdata[HALF_W-1:0] == '0;
				end
				CFG_HALF_Y: begin
					half_q[1] <= cfg_wdata[HALF_W-1:0];
					lo_q[1] <= lo_h[1];
					hi_q[1] <= hi_h[1];
					flat_q[1] <= cfg_wdata[HALF_W-1:0] == '0;
				end
				CFG_HALF_Z: begin
					half_q[2] <= cfg_wdata[HALF_W-1:0];
					lo_q[2] <= lo_h[2];
					hi_q[2] <= hi_h[2];
					flat_q[2] <= cfg_wdata[HALF_W-1:0] == '0;
				end
				default: begin
					// Writes past the register list are dropped.
				end
			endcase
		end
	end

	apsq_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.box           (box),
		.q_stat        (q_stat),
		.push          (push),
		.push_data     (push_data)
	);

	apsq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	apsq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop_data      (pop_data),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Result fields, unpacked for the checks below.
	logic [COORD_W-1:0] chk_surf [NUM_AXES];
	logic [NORM_W-1:0] chk_norm [NUM_AXES];

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			chk_surf[a] = m_axis_tdata[1 + a*COORD_W +: COORD_W];
			chk_norm[a] = m_axis_tdata[1 + NUM_AXES*COORD_W + a*NORM_W +: NORM_W];
		end
	end

	// Every result touches at least one face: clamped outside, pushed out inside.
	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (chk_norm[0] != '0 || chk_norm[1] != '0 || chk_norm[2] != '0))
		else $error("result normal is zero");

	// The surface point always lies on or within the current box.
	a_surf_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			($signed(chk_surf[0]) >= $signed(lo_q[0]) && $signed(chk_surf[0]) <= $signed(hi_q[0])
			&& $signed(chk_surf[1]) >= $signed(lo_q[1])
			&& $signed(chk_surf[1]) <= $signed(hi_q[1])
			&& $signed(chk_surf[2]) >= $signed(lo_q[2])
			&& $signed(chk_surf[2]) <= $signed(hi_q[2])))
		else $error("surface point outside the box");

	// The front end stalls only when the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_stat.full && !q_stat.empty)
		else $error("input stalled with room in the queue");

endmodule

// ===== rtl/apsq_front.sv =====
// Front end: takes query points and classifies each axis against the box.
`timescale 1ns / 1ps

module apsq_front
	import apsq_pkg::*;
(
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata, // point_x, point_y, point_z
	input  box_t                  box,
	input  q_status_t             q_stat,
	output logic                  push,
	output cls_t                  push_data
);

	logic [NUM_AXES-1:0] in_slab;

	assign s_axis_tready = !q_stat.full;
	assign push = s_axis_tvalid && !q_stat.full;

	always_comb begin
		logic [COORD_W:0] dlo;
		logic [COORD_W:0] dhi;
		logic [COORD_W-1:0] p;
		for (int a = 0; a < NUM_AXES; a++) begin
			p = s_axis_tdata[a*COORD_W +: COORD_W];
			push_data.ax[a].p = p;
			push_data.ax[a].lo = box[a].lo;
			push_data.ax[a].hi = box[a].hi;
			push_data.ax[a].flat = box[a].flat;
			push_data.ax[a].below = $signed(p) < $signed(box[a].lo);
			push_data.ax[a].above = $signed(p) > $signed(box[a].hi);
			push_data.ax[a].eq_lo = p == box[a].lo;
			push_data.ax[a].eq_hi = p == box[a].hi;
			// Distances only matter inside the box, where they fit in 31 bits.
			dlo = {p[COORD_W-1], p} - {box[a].lo[COORD_W-1], box[a].lo};
			dhi = {box[a].hi[COORD_W-1], box[a].hi} - {p[COORD_W-1], p};
			push_data.ax[a].dmin = dlo[DIST_W-1:0];
			push_data.ax[a].dmax = dhi[DIST_W-1:0];
			in_slab[a] = !push_data.ax[a].below && !push_data.ax[a].above;
		end
		push_data.is_inside = &in_slab;
	end

endmodule

// ===== rtl/apsq_queue.sv =====
// Short FIFO that decouples the classifying front end from the back end.
`timescale 1ns / 1ps

module apsq_queue
	import apsq_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_t      push_data,
	input  logic      pop,
	output cls_t      pop_data,
	output q_status_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cls_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_pop;

	assign q_stat.full = count_q == CNT_W'(DEPTH);
	assign q_stat.empty = count_q == '0;
	assign do_pop = pop && !q_stat.empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/apsq_back.sv =====
// Back end: picks the nearest face, forms the surface point and the unit normal.
`timescale 1ns / 1ps

module apsq_back
	import apsq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  q_status_t              q_stat,
	input  cls_t                   pop_data,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// inside_res, surf_x, surf_y, surf_z, norm_x, norm_y, norm_z, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	typedef struct packed {
		logic [COORD_W-1:0] p;
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic below;
		logic above;
		logic eq_lo;
		logic eq_hi;
		logic flat;
		logic sel_max;
		logic [DIST_W-1:0] dbest;
	} axis_s1_t;

	typedef struct packed {
		logic is_inside;
		axis_s1_t [NUM_AXES-1:0] ax;
	} item_s1_t;

	logic advance;
	logic valid_s1;
	item_s1_t item_s1;
	item_s1_t item_d;
	logic m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_FIELDS_W-1:0] fields_d;

	assign advance = !m_tvalid_q || m_axis_tready;
	assign pop = advance && !q_stat.empty;

	// First stage: nearer face of each axis, max face only when strictly nearer.
	always_comb begin
		item_d.is_inside = pop_data.is_inside;
		for (int a = 0; a < NUM_AXES; a++) begin
			item_d.ax[a].p = pop_data.ax[a].p;
			item_d.ax[a].lo = pop_data.ax[a].lo;
			item_d.ax[a].hi = pop_data.ax[a].hi;
			item_d.ax[a].below = pop_data.ax[a].below;
			item_d.ax[a].above = pop_data.ax[a].above;
			item_d.ax[a].eq_lo = pop_data.ax[a].eq_lo;
			item_d.ax[a].eq_hi = pop_data.ax[a].eq_hi;
			item_d.ax[a].flat = pop_data.ax[a].flat;
			item_d.ax[a].sel_max = pop_data.ax[a].dmax < pop_data.ax[a].dmin;
			item_d.ax[a].dbest = item_d.ax[a].sel_max ? pop_data.ax[a].dmax
				: pop_data.ax[a].dmin;
		end
	end

	// Second stage: nearest axis, earlier axis wins a tie.
	always_comb begin
		logic y_win;
		logic z_win;
		logic [DIST_W-1:0] d01;
		logic [NUM_AXES-1:0] pick;
		logic [NUM_AXES-1:0] at_lo;
		logic [NUM_AXES-1:0] at_hi;
		logic [NUM_AXES-1:0] neg;
		logic [NUM_AXES-1:0] pos;
		logic [1:0] cnt;
		logic [NORM_W-1:0] scale;
		logic [COORD_W-1:0] surf [NUM_AXES];
		logic [NORM_W-1:0] norm [NUM_AXES];

		y_win = item_s1.ax[1].dbest < item_s1.ax[0].dbest;
		d01 = y_win ? item_s1.ax[1].dbest : item_s1.ax[0].dbest;
		z_win = item_s1.ax[2].dbest < d01;
		pick[2] = z_win;
		pick[1] = !z_win && y_win;
		pick[0] = !z_win && !y_win;

		for (int a = 0; a < NUM_AXES; a++) begin
			if (item_s1.is_inside) begin
				at_lo[a] = pick[a] && !item_s1.ax[a].sel_max;
				at_hi[a] = pick[a] && item_s1.ax[a].sel_max;
			end else begin
				at_lo[a] = item_s1.ax[a].below;
				at_hi[a] = item_s1.ax[a].above;
			end
			if (at_lo[a]) begin
				surf[a] = item_s1.ax[a].lo;
			end else if (at_hi[a]) begin
				surf[a] = item_s1.ax[a].hi;
			end else begin
				surf[a] = item_s1.ax[a].p;
			end
			// A point on a zero-width slab counts as on the min face.
			neg[a] = at_lo[a] || (at_hi[a] && item_s1.ax[a].flat)
				|| (!at_lo[a] && !at_hi[a] && item_s1.ax[a].eq_lo);
			pos[a] = !neg[a] && (at_hi[a] || (!at_lo[a] && item_s1.ax[a].eq_hi));
		end

		cnt = 2'({1'b0, neg[0] || pos[0]} + {1'b0, neg[1] || pos[1]}
			+ {1'b0, neg[2] || pos[2]});
		scale = norm_scale(cnt);

		for (int a = 0; a < NUM_AXES; a++) begin
			if (neg[a]) begin
				norm[a] = -scale;
			end else if (pos[a]) begin
				norm[a] = scale;
			end else begin
				norm[a] = '0;
			end
		end

		fields_d = {norm[2], norm[1], norm[0], surf[2], surf[1], surf[0],
			item_s1.is_inside};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= item_d;
		end
		if (advance && valid_s1) begin
			m_tdata_q <= OUT_TDATA_W'(fields_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= !q_stat.empty;
			m_tvalid_q <= valid_s1;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata = m_tdata_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking stream testbench for the box point surface query core.
`timescale 1ns / 1ps

// Points go in on the slave stream from a queue that the main initial block fills.
// Results come back on the master stream. The expected result for each point is
// worked out when its transfer is accepted, from a local copy of the box registers.
// The box is only rewritten while the stream is drained, so that copy always holds
// the box that the point saw. The run has directed points at the reset box, then a
// flat box, and then random phases. The phases cover the largest and smallest
// boxes, flat boxes, tiny boxes and random boxes. Each phase uses one of four mixes of
// sender gaps and receiver stalls.
module tb_top;
	import apsq_pkg::*;

	// One result, laid out exactly as on m_axis_tdata (inside flag in bit 0).
	typedef struct packed {
		logic [NORM_W-1:0] norm_z;
		logic [NORM_W-1:0] norm_y;
		logic [NORM_W-1:0] norm_x;
		logic [COORD_W-1:0] surf_z;
		logic [COORD_W-1:0] surf_y;
		logic [COORD_W-1:0] surf_x;
		logic is_inside;
	} surf_result_t;

	// Address codes that decode to no register; writes to them must be ignored.
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 3'd7;

	localparam int RANDOM_PHASES = 9;
	localparam int POINTS_PER_PHASE = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Local copy of the box registers, in their register widths.
	logic [CENTER_W-1:0] box_center [NUM_AXES];
	logic [HALF_W-1:0] box_half [NUM_AXES];

	logic [IN_TDATA_W-1:0] point_pending [$];
	surf_result_t surf_expected [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;

	aabb_point_surface_query_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the closest surface point and the face normal of one query point.
	// The bounds are formed in 64 bits. They always fit in 32 signed bits, so the
	// surface point is truncated back without any loss.
	function automatic surf_result_t predict_surface(input logic [IN_TDATA_W-1:0] pt);
		longint p [NUM_AXES];
		longint lo [NUM_AXES];
		longint hi [NUM_AXES];
		longint s [NUM_AXES];
		int dir [NUM_AXES];
		logic [COORD_W-1:0] sv [NUM_AXES];
		logic [NORM_W-1:0] nv [NUM_AXES];
		logic [NORM_W-1:0] mag;
		logic pt_inside;
		logic face_max;
		int face_axis;
		int hits;
		longint best;
		surf_result_t r;
		pt_inside = 1'b1;
		for (int a = 0; a < NUM_AXES; a++) begin
			p[a] = longint'($signed(pt[a*COORD_W +: COORD_W]));
			lo[a] = longint'($signed(box_center[a])) - longint'(box_half[a]);
			hi[a] = longint'($signed(box_center[a])) + longint'(box_half[a]);
			if (p[a] < lo[a] || p[a] > hi[a])
				pt_inside = 1'b0;
		end
		if (!pt_inside) begin
			// Outside: clamp every axis into its slab.
			for (int a = 0; a < NUM_AXES; a++)
				s[a] = (p[a] < lo[a]) ? lo[a] : ((p[a] > hi[a]) ? hi[a] : p[a]);
		end else begin
			// Inside: push onto the nearest face. Faces are ranked x-min, x-max,
			// y-min and so on, and a later face has to be strictly nearer to win.
			face_axis = 0;
			face_max = 1'b0;
			best = p[0] - lo[0];
			for (int a = 0; a < NUM_AXES; a++) begin
				if (p[a] - lo[a] < best) begin
					best = p[a] - lo[a];
					face_axis = a;
					face_max = 1'b0;
				end
				if (hi[a] - p[a] < best) begin
					best = hi[a] - p[a];
					face_axis = a;
					face_max = 1'b1;
				end
			end
			for (int a = 0; a < NUM_AXES; a++)
				s[a] = p[a];
			s[face_axis] = face_max ? hi[face_axis] : lo[face_axis];
		end
		// The min face is tested first, so a flat axis always points negative.
		hits = 0;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (s[a] == lo[a])
				dir[a] = -1;
			else if (s[a] == hi[a])
				dir[a] = 1;
			else
				dir[a] = 0;
			if (dir[a] != 0)
				hits++;
		end
		case (hits)
			1: mag = NORM_ONE;
			2: mag = NORM_SQRT2;
			3: mag = NORM_SQRT3;
			default: mag = '0;
		endcase
		for (int a = 0; a < NUM_AXES; a++) begin
			sv[a] = s[a][COORD_W-1:0];
			nv[a] = (dir[a] < 0) ? -mag : ((dir[a] > 0) ? mag : '0);
		end
		r.is_inside = pt_inside;
		r.surf_x = sv[0];
		r.surf_y = sv[1];
		r.surf_z = sv[2];
		r.norm_x = nv[0];
		r.norm_y = nv[1];
		r.norm_z = nv[2];
		return r;
	endfunction

	// One coordinate on an axis. Most picks land on or near the box faces, where
	// the interesting decisions are made. When in_slab is set, the pick stays
	// within the slab.
	function automatic logic [COORD_W-1:0] pick_coord(input int a, input logic in_slab);
		longint c;
		longint lo;
		longint hi;
		longint span;
		longint off;
		longint v;
		c = longint'($signed(box_center[a]));
		lo = c - longint'(box_half[a]);
		hi = c + longint'(box_half[a]);
		span = hi - lo;
		off = longint'($urandom_range(0, span[31:0]));
		case (in_slab ? $urandom_range(0, 5) : $urandom_range(0, 11))
			0: v = lo;
			1: v = hi;
			2: v = c;
			3: v = lo + ((span < 3) ? span : longint'($urandom_range(0, 3)));
			4: v = hi - ((span < 3) ? span : longint'($urandom_range(0, 3)));
			5: v = lo + off;
			6: v = lo - 1;
			7: v = hi + 1;
			8: v = longint'($urandom());
			9: v = ($urandom_range(0, 1) != 0) ? 64'h7fff_ffff : 64'h8000_0000;
			default: v = lo + off;
		endcase
		return v[COORD_W-1:0];
	endfunction

	// Fills the point queue. Each point is picked inside the box with a chance of 40 in
	// 100, since only points inside the box exercise the face ranking.
	task automatic queue_points(input int count);
		logic in_box;
		for (int i = 0; i < count; i++) begin
			in_box = ($urandom_range(0, 99) < 40);
			point_pending.push_back({pick_coord(2, in_box), pick_coord(1, in_box),
				pick_coord(0, in_box)});
		end
	endtask

	task automatic queue_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z);
		point_pending.push_back({z, y, x});
	endtask

	// Waits until every queued point has been sent and every result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (point_pending.size() != 0 || s_axis_tvalid || surf_expected.size() != 0);
	endtask

	task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			CFG_CENTER_X: box_center[0] = data[CENTER_W-1:0];
			CFG_CENTER_Y: box_center[1] = data[CENTER_W-1:0];
			CFG_CENTER_Z: box_center[2] = data[CENTER_W-1:0];
			CFG_HALF_X: box_half[0] = data[HALF_W-1:0];
			CFG_HALF_Y: box_half[1] = data[HALF_W-1:0];
			CFG_HALF_Z: box_half[2] = data[HALF_W-1:0];
			default: ;
		endcase
	endtask

	// Writes the whole box. The unused top bit of each half extent write gets a
	// random value, since the register has to drop it.
	task automatic set_box(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
		input logic [CENTER_W-1:0] cz, input logic [HALF_W-1:0] hx,
		input logic [HALF_W-1:0] hy, input logic [HALF_W-1:0] hz);
		cfg_write(CFG_CENTER_X, cx);
		cfg_write(CFG_CENTER_Y, cy);
		cfg_write(CFG_CENTER_Z, cz);
		cfg_write(CFG_HALF_X, {1'($urandom_range(0, 1)), hx});
		cfg_write(CFG_HALF_Y, {1'($urandom_range(0, 1)), hy});
		cfg_write(CFG_HALF_Z, {1'($urandom_range(0, 1)), hz});
	endtask

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] want,
		input logic [COORD_W-1:0] got);
		if (got !== want)
			report($sformatf("%s expected %h, got %h", name, want, got));
	endtask

	// Driver: a new point may be put up whenever the slot is empty or the current
	// point is being taken. The expectation is formed at the edge that accepts the
	// transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				surf_expected.push_back(predict_surface(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (point_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= point_pending.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each accepted result is checked against the oldest expectation.
	always @(posedge clk) begin : result_monitor
		surf_result_t got;
		surf_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[OUT_FIELDS_W-1:0];
				if (surf_expected.size() == 0) begin
					report($sformatf("result with nothing expected: %h", got));
				end else begin
					want = surf_expected.pop_front();
					check_field("inside_res", COORD_W'(want.is_inside),
						COORD_W'(got.is_inside));
					check_field("surf_x", want.surf_x, got.surf_x);
					check_field("surf_y", want.surf_y, got.surf_y);
					check_field("surf_z", want.surf_z, got.surf_z);
					check_field("norm_x", COORD_W'(want.norm_x), COORD_W'(got.norm_x));
					check_field("norm_y", COORD_W'(want.norm_y), COORD_W'(got.norm_y));
					check_field("norm_z", COORD_W'(want.norm_z), COORD_W'(got.norm_z));
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		for (int a = 0; a < NUM_AXES; a++) begin
			box_center[a] = '0;
			box_half[a] = HALF_RESET;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed points against the reset box: center zero, half extent 1.0.
		// At the center all six faces tie, and x-min has to win.
		queue_point(32'd0, 32'd0, 32'd0);
		// Corners on the max side and on the min side touch three faces.
		queue_point(32'd65536, 32'd65536, 32'd65536);
		queue_point(-32'sd65536, -32'sd65536, -32'sd65536);
		// The extremes of the fields are far outside the box and get clamped.
		queue_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_point(32'h7fff_ffff, 32'h8000_0000, 32'd0);
		// Just outside one face, and just outside two.
		queue_point(32'd65537, 32'd0, 32'd0);
		queue_point(-32'sd65537, 32'd65537, 32'd5);
		// An edge point inside, and an ordinary point inside.
		queue_point(32'd65536, 32'd65536, 32'd0);
		queue_point(32'd100, 32'd200, -32'sd300);
		// A tie between y-min and z-max: the y-min face wins.
		queue_point(32'd0, -32'sd32768, 32'd32768);
		// A tie between x-max and z-min at a smaller distance than all the others.
		queue_point(32'd65000, 32'd0, -32'sd65000);
		wait_drained();

		// A flat box in x: lo equals hi, and the min face has to take the normal.
		set_box(31'h1234, -31'sd5, 31'd0, 30'd0, 30'd65536, 30'd65536);
		cfg_write(CFG_SPARE_A, CFG_DATA_W'($urandom()));
		cfg_write(CFG_SPARE_B, CFG_DATA_W'($urandom()));
		@(negedge clk);
		queue_point(32'h1234, 32'd0, 32'd0);
		queue_point(32'h1235, 32'd0, 32'd0);
		queue_point(32'h1233, 32'd65531, -32'sd65536);
		queue_point(32'h1234, -32'sd5, 32'd65536);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				// Largest box on the positive side: hi reaches 2^31 - 2.
				0: set_box(31'h3fff_ffff, 31'h3fff_ffff, 31'h3fff_ffff,
					30'h3fff_ffff, 30'h3fff_ffff, 30'h3fff_ffff);
				// Largest box on the negative side: lo reaches -2^31 + 1.
				1: set_box(31'h4000_0000, 31'h4000_0000, 31'h4000_0000,
					30'h3fff_ffff, 30'h3fff_ffff, 30'h3fff_ffff);
				// A box that is only a point.
				2: set_box(CENTER_W'($urandom()), CENTER_W'($urandom()),
					CENTER_W'($urandom()), 30'd0, 30'd0, 30'd0);
				// Tiny boxes make ties and corner hits common.
				3: set_box(CENTER_W'($urandom()), CENTER_W'($urandom()),
					CENTER_W'($urandom()), HALF_W'($urandom_range(0, 3)),
					HALF_W'($urandom_range(0, 3)), HALF_W'($urandom_range(0, 3)));
				4: set_box(31'd0, 31'd0, 31'd0, 30'h3fff_ffff, 30'h3fff_ffff, 30'h3fff_ffff);
				// Mixed: a flat x, the largest y and a tiny z.
				5: set_box(CENTER_W'($urandom()), CENTER_W'($urandom()),
					CENTER_W'($urandom()), 30'd0, 30'h3fff_ffff,
					HALF_W'($urandom_range(0, 7)));
				default: set_box(CENTER_W'($urandom()), CENTER_W'($urandom()),
					CENTER_W'($urandom()), HALF_W'($urandom()), HALF_W'($urandom()),
					HALF_W'($urandom()));
			endcase
			@(negedge clk);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 45;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 45;
				end
				default: begin
					send_idle_pct = 27;
					recv_stall_pct = 27;
				end
			endcase
			// The sender holds back halfway through, until every result is in.
			queue_points(POINTS_PER_PHASE / 2);
			wait_drained();
			queue_points(POINTS_PER_PHASE - POINTS_PER_PHASE / 2);
			wait_drained();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		if (mismatches == 0 && surf_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
